// File: hdl/one_wire_temperature_reader_defines.svh
// Assertion macros shared by the one-wire temperature reader modules.
`ifndef ONE_WIRE_TEMPERATURE_READER_DEFINES_SVH
`define ONE_WIRE_TEMPERATURE_READER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define OWTR_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("one-wire reader assertion failed");
`define OWTR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("one-wire reader assertion failed");
`define OWTR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("one-wire reader assertion failed");
`else
`define OWTR_ASSERT(lbl, expr)
`define OWTR_ASSERT_IMP(lbl, ante, cons)
`define OWTR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/owtr_pkg.sv
// Types, constants and helpers for the one-wire temperature reader.
package owtr_pkg;

  localparam int unsigned WAIT_W      = 20;
  localparam int unsigned TIMER_W     = 20;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned BITCNT_W    = 5;
  localparam int unsigned READ_BITS   = 16;

  localparam logic [WAIT_W-1:0] CONV_WAIT_RESET = 20'd750000;

  localparam logic [TIMER_W:0] RST_LOW_US    = 21'd480;
  localparam logic [TIMER_W:0] RST_SAMPLE_US = 21'd60;
  localparam logic [TIMER_W:0] RST_SETTLE_US = 21'd420;
  localparam logic [TIMER_W:0] SLOT_WRITE_US = 21'd61;
  localparam logic [TIMER_W:0] SLOT_READ_US  = 21'd60;
  localparam logic [TIMER_W-1:0] SHORT_LOW_US = 20'd5;
  localparam logic [TIMER_W-1:0] LONG_LOW_US  = 20'd60;
  localparam logic [TIMER_W-1:0] PRESENCE_AT  = 20'd59;
  localparam logic [TIMER_W-1:0] READ_SAMPLE_AT = 20'd14;
  localparam logic [BITCNT_W-1:0] CMD_BITS  = 5'd8;
  localparam logic [BITCNT_W-1:0] READ_BITS_C = 5'(READ_BITS);

  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE, PH_R1_LOW, PH_R1_WAIT, PH_R1_SETTLE, PH_SKIP1, PH_CONVERT,
    PH_CONV_WAIT, PH_R2_LOW, PH_R2_WAIT, PH_R2_SETTLE, PH_SKIP2, PH_READPAD,
    PH_READ
  } phase_t;

  typedef struct packed {
    logic kind;
    logic bus_level;
  } in_beat_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              presence_seen;
    logic [WORD_W-1:0] raw_word;
    logic              is_negative;
    logic [WORD_W-1:0] magnitude;
  } out_beat_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy;
    logic              done;
    logic              present;
    logic [WORD_W-1:0] word;
  } owtr_status_t;

  function automatic phase_t next_phase(phase_t p);
    phase_t n;
    unique case (p)
      PH_R1_LOW:    n = PH_R1_WAIT;
      PH_R1_WAIT:   n = PH_R1_SETTLE;
      PH_R1_SETTLE: n = PH_SKIP1;
      PH_SKIP1:     n = PH_CONVERT;
      PH_CONVERT:   n = PH_CONV_WAIT;
      PH_R2_LOW:    n = PH_R2_WAIT;
      PH_R2_WAIT:   n = PH_R2_SETTLE;
      PH_R2_SETTLE: n = PH_SKIP2;
      PH_SKIP2:     n = PH_READPAD;
      PH_READPAD:   n = PH_READ;
      default:      n = PH_IDLE;
    endcase
    return n;
  endfunction

endpackage

// File: hdl/owtr_seq.sv
// Bus sequencer: phase, slot timer, bit counter and shift registers.
`include "one_wire_temperature_reader_defines.svh"
module owtr_seq (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  step,
  input  owtr_pkg::in_beat_t                    beat,
  input  logic [owtr_pkg::WAIT_W-1:0]           conv_wait,
  output owtr_pkg::owtr_status_t                status
);

  owtr_pkg::phase_t                   phase_r, phase_nxt;
  logic [owtr_pkg::TIMER_W-1:0]       timer_r, timer_nxt;
  logic [owtr_pkg::BITCNT_W-1:0]      bit_r, bit_nxt;
  logic [7:0]                         obyte_r, obyte_nxt;
  logic [owtr_pkg::WORD_W-1:0]        shift_r, shift_nxt;
  logic                               pres_r, pres_nxt;
  logic [owtr_pkg::WORD_W-1:0]        word_r, word_nxt;

  logic [owtr_pkg::TIMER_W:0]         tinc;
  logic [owtr_pkg::BITCNT_W-1:0]      binc;
  logic                               is_tick;
  logic                               ent_en;
  owtr_pkg::phase_t                   ent_ph;
  owtr_pkg::phase_t                   ent_fix;
  logic                               drive;
  logic                               done;

  assign tinc    = {1'b0, timer_r} + 21'd1;
  assign binc    = bit_r + 5'd1;
  assign is_tick = step && (beat.kind == owtr_pkg::KIND_TICK);
  assign ent_fix = (ent_ph == owtr_pkg::PH_CONV_WAIT && conv_wait == '0)
                   ? owtr_pkg::PH_R2_LOW : ent_ph;

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    bit_nxt   = bit_r;
    obyte_nxt = obyte_r;
    shift_nxt = shift_r;
    pres_nxt  = pres_r;
    word_nxt  = word_r;
    ent_en    = 1'b0;
    ent_ph    = owtr_pkg::PH_IDLE;
    if (step && beat.kind == owtr_pkg::KIND_START) begin
      if (phase_r == owtr_pkg::PH_IDLE) begin
        ent_en = 1'b1;
        ent_ph = owtr_pkg::PH_R1_LOW;
      end
    end else if (is_tick) begin
      unique case (phase_r)
        owtr_pkg::PH_IDLE: begin
        end
        owtr_pkg::PH_R1_LOW, owtr_pkg::PH_R2_LOW: begin
          timer_nxt = tinc[owtr_pkg::TIMER_W-1:0];
          if (tinc >= owtr_pkg::RST_LOW_US) begin
            ent_en = 1'b1;
            ent_ph = owtr_pkg::next_phase(phase_r);
          end
        end
        owtr_pkg::PH_R1_WAIT, owtr_pkg::PH_R2_WAIT: begin
          if (timer_r == owtr_pkg::PRESENCE_AT) begin
            pres_nxt = !beat.bus_level;
          end
          timer_nxt = tinc[owtr_pkg::TIMER_W-1:0];
          if (tinc >= owtr_pkg::RST_SAMPLE_US) begin
            ent_en = 1'b1;
            ent_ph = owtr_pkg::next_phase(phase_r);
          end
        end
        owtr_pkg::PH_R1_SETTLE, owtr_pkg::PH_R2_SETTLE: begin
          timer_nxt = tinc[owtr_pkg::TIMER_W-1:0];
          if (tinc >= owtr_pkg::RST_SETTLE_US) begin
            ent_en = 1'b1;
            ent_ph = owtr_pkg::next_phase(phase_r);
          end
        end
        owtr_pkg::PH_SKIP1, owtr_pkg::PH_CONVERT, owtr_pkg::PH_SKIP2,
        owtr_pkg::PH_READPAD: begin
          timer_nxt = tinc[owtr_pkg::TIMER_W-1:0];
          if (tinc >= owtr_pkg::SLOT_WRITE_US) begin
            timer_nxt = '0;
            obyte_nxt = {1'b0, obyte_r[7:1]};
            bit_nxt   = binc;
            if (binc >= owtr_pkg::CMD_BITS) begin
              ent_en = 1'b1;
              ent_ph = owtr_pkg::next_phase(phase_r);
            end
          end
        end
        owtr_pkg::PH_CONV_WAIT: begin
          timer_nxt = tinc[owtr_pkg::TIMER_W-1:0];
          if (tinc >= {1'b0, conv_wait}) begin
            ent_en = 1'b1;
            ent_ph = owtr_pkg::PH_R2_LOW;
          end
        end
        owtr_pkg::PH_READ: begin
          if (timer_r == owtr_pkg::READ_SAMPLE_AT && beat.bus_level) begin
            shift_nxt[bit_r[3:0]] = 1'b1;
          end
          timer_nxt = tinc[owtr_pkg::TIMER_W-1:0];
          if (tinc >= owtr_pkg::SLOT_READ_US) begin
            timer_nxt = '0;
            bit_nxt   = binc;
            if (binc >= owtr_pkg::READ_BITS_C) begin
              word_nxt  = shift_nxt;
              phase_nxt = owtr_pkg::PH_IDLE;
              bit_nxt   = '0;
            end
          end
        end
        default: begin
          phase_nxt = owtr_pkg::PH_IDLE;
        end
      endcase
    end
    if (ent_en) begin
      phase_nxt = ent_fix;
      timer_nxt = '0;
      bit_nxt   = '0;
      if (ent_fix == owtr_pkg::PH_SKIP1 || ent_fix == owtr_pkg::PH_SKIP2) begin
        obyte_nxt = owtr_pkg::CMD_SKIP_ROM;
      end else if (ent_fix == owtr_pkg::PH_CONVERT) begin
        obyte_nxt = owtr_pkg::CMD_CONVERT;
      end else if (ent_fix == owtr_pkg::PH_READPAD) begin
        obyte_nxt = owtr_pkg::CMD_READ_PAD;
      end
      if (ent_fix == owtr_pkg::PH_READ) begin
        shift_nxt = '0;
      end
    end
  end

  always_comb begin
    drive = 1'b0;
    done  = 1'b0;
    if (is_tick) begin
      unique case (phase_r)
        owtr_pkg::PH_R1_LOW, owtr_pkg::PH_R2_LOW: begin
          drive = 1'b1;
        end
        owtr_pkg::PH_SKIP1, owtr_pkg::PH_CONVERT, owtr_pkg::PH_SKIP2,
        owtr_pkg::PH_READPAD: begin
          drive = obyte_r[0] ? (timer_r < owtr_pkg::SHORT_LOW_US)
                             : (timer_r < owtr_pkg::LONG_LOW_US);
        end
        owtr_pkg::PH_READ: begin
          drive = timer_r < owtr_pkg::SHORT_LOW_US;
          done  = (tinc >= owtr_pkg::SLOT_READ_US) && (binc >= owtr_pkg::READ_BITS_C);
        end
        default: begin
          drive = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= owtr_pkg::PH_IDLE;
      timer_r <= '0;
      bit_r   <= '0;
      obyte_r <= '0;
      shift_r <= '0;
      pres_r  <= 1'b0;
      word_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      bit_r   <= bit_nxt;
      obyte_r <= obyte_nxt;
      shift_r <= shift_nxt;
      pres_r  <= pres_nxt;
      word_r  <= word_nxt;
    end
  end

  assign status.drive_low = drive;
  assign status.busy      = (phase_nxt != owtr_pkg::PH_IDLE);
  assign status.done      = done;
  assign status.present   = pres_nxt;
  assign status.word      = word_nxt;

  `OWTR_ASSERT_NEXT(a_done_goes_idle, done, phase_r == owtr_pkg::PH_IDLE)
  `OWTR_ASSERT_IMP(a_drive_when_busy, drive, phase_r != owtr_pkg::PH_IDLE)
  `OWTR_ASSERT_IMP(a_read_bits_bound, phase_r == owtr_pkg::PH_READ,
                   bit_r < owtr_pkg::READ_BITS_C)
  `OWTR_ASSERT_IMP(a_write_slot_bound,
                   phase_r == owtr_pkg::PH_SKIP1 || phase_r == owtr_pkg::PH_CONVERT ||
                   phase_r == owtr_pkg::PH_SKIP2 || phase_r == owtr_pkg::PH_READPAD,
                   {1'b0, timer_r} < owtr_pkg::SLOT_WRITE_US && bit_r < owtr_pkg::CMD_BITS)

endmodule

// File: hdl/one_wire_temperature_reader.sv
// Top level of the one-wire bus master that runs a full temperature read.
//
// Input beats on in_data carry a kind (start or one-microsecond tick) and the
// sampled line level. Every accepted input beat yields exactly one result beat
// on out_data: the drive level for that tick, busy and done flags, the presence
// flag and the last word read with its sign and magnitude in sixteenths.
// The result of a beat accepted at one edge is registered and valid from the
// next. Throughput is one beat per cycle while the receiver takes the results;
// the sequencer updates its phase, slot timer and bit counter once per beat.
// The result register parts the two sides: in_ready is high while the result
// register is empty or being taken, so a stalled receiver holds back input
// only once a result is waiting.
// cfg_wr_en writes the conversion wait in microseconds at once; it should be
// written only while no read is in progress.
// Reset (synchronous, active low) returns the sequencer to idle, clears the
// flags and stored word and sets the conversion wait to 750000.
`include "one_wire_temperature_reader_defines.svh"
module one_wire_temperature_reader (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  owtr_pkg::in_beat_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output owtr_pkg::out_beat_t          out_data,
  input  logic                         cfg_wr_en,
  input  logic [owtr_pkg::WAIT_W-1:0]  cfg_wr_data
);

  logic [owtr_pkg::WAIT_W-1:0] conv_wait_r;
  logic                        out_valid_r, out_valid_nxt;
  owtr_pkg::out_beat_t         out_data_r, out_data_nxt;
  owtr_pkg::owtr_status_t      status;
  logic                        step;

  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  owtr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .beat      (in_data),
    .conv_wait (conv_wait_r),
    .status    (status)
  );

  always_comb begin
    out_data_nxt.drive_low      = status.drive_low;
    out_data_nxt.busy_res       = status.busy;
    out_data_nxt.done_res       = status.done;
    out_data_nxt.presence_seen  = status.present;
    out_data_nxt.raw_word       = status.word;
    out_data_nxt.is_negative    = status.word[owtr_pkg::WORD_W-1];
    out_data_nxt.magnitude      = status.word[owtr_pkg::WORD_W-1] ? (~status.word + 16'd1)
                                                                  : status.word;
    out_valid_nxt = step ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_wait_r <= owtr_pkg::CONV_WAIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        conv_wait_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `OWTR_ASSERT_IMP(a_mag_positive, out_valid_r && !out_data_r.is_negative,
                   out_data_r.magnitude == out_data_r.raw_word)
  `OWTR_ASSERT_IMP(a_sign_bit, out_valid_r,
                   out_data_r.is_negative == out_data_r.raw_word[owtr_pkg::WORD_W-1])
  `OWTR_ASSERT_IMP(a_done_not_busy, out_valid_r && out_data_r.done_res,
                   !out_data_r.busy_res)

endmodule

// File: test/owtr_result_checker.sv
`timescale 1ns / 1ps
// Checker that predicts each result beat of the one-wire temperature reader and compares it.
module owtr_result_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  owtr_pkg::in_beat_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  owtr_pkg::out_beat_t         out_data,
  input  logic                        cfg_wr_en,
  input  logic [owtr_pkg::WAIT_W-1:0] cfg_wr_data,
  output int                          mismatches,
  output int                          pending
);

  localparam logic [20:0] RESET_LOW_US    = 21'd480;
  localparam logic [20:0] PRESENCE_WIN_US = 21'd60;
  localparam logic [20:0] SETTLE_US       = 21'd420;
  localparam logic [20:0] WRITE_SLOT_US   = 21'd61;
  localparam logic [20:0] READ_SLOT_US    = 21'd60;
  localparam logic [20:0] READ_SAMPLE_US  = 21'd14;
  localparam logic [20:0] SHORT_PULSE_US  = 21'd5;
  localparam logic [20:0] LONG_PULSE_US   = 21'd60;
  localparam logic [7:0]  OP_SKIP_ROM     = 8'hCC;
  localparam logic [7:0]  OP_CONVERT      = 8'h44;
  localparam logic [7:0]  OP_READ_PAD     = 8'hBE;

  owtr_pkg::out_beat_t expected_q[$];

  logic [19:0]      conv_wait_us;
  owtr_pkg::phase_t seq_phase;
  logic [20:0]      slot_us;
  logic [4:0]       bit_idx;
  logic [7:0]       cmd_byte;
  logic [15:0]      shift_word;
  logic             present;
  logic [15:0]      last_word;

  function void enter_phase(input owtr_pkg::phase_t target);
    owtr_pkg::phase_t p;
    p = target;
    if (p == owtr_pkg::PH_CONV_WAIT && conv_wait_us == 20'd0) p = owtr_pkg::PH_R2_LOW;
    seq_phase = p;
    slot_us = '0;
    bit_idx = '0;
    if (p == owtr_pkg::PH_SKIP1 || p == owtr_pkg::PH_SKIP2) cmd_byte = OP_SKIP_ROM;
    else if (p == owtr_pkg::PH_CONVERT) cmd_byte = OP_CONVERT;
    else if (p == owtr_pkg::PH_READPAD) cmd_byte = OP_READ_PAD;
    if (p == owtr_pkg::PH_READ) shift_word = '0;
  endfunction

  function owtr_pkg::out_beat_t predict_result(input owtr_pkg::in_beat_t beat);
    owtr_pkg::out_beat_t r;
    logic drive;
    logic done;
    drive = 1'b0;
    done = 1'b0;
    if (beat.kind == owtr_pkg::KIND_START) begin
      if (seq_phase == owtr_pkg::PH_IDLE) enter_phase(owtr_pkg::PH_R1_LOW);
    end else if (seq_phase != owtr_pkg::PH_IDLE) begin
      case (seq_phase)
        owtr_pkg::PH_R1_LOW, owtr_pkg::PH_R2_LOW: begin
          drive = 1'b1;
          slot_us = slot_us + 21'd1;
          if (slot_us >= RESET_LOW_US) enter_phase(owtr_pkg::phase_t'(seq_phase + 4'd1));
        end
        owtr_pkg::PH_R1_WAIT, owtr_pkg::PH_R2_WAIT: begin
          if (slot_us == PRESENCE_WIN_US - 21'd1) present = !beat.bus_level;
          slot_us = slot_us + 21'd1;
          if (slot_us >= PRESENCE_WIN_US) enter_phase(owtr_pkg::phase_t'(seq_phase + 4'd1));
        end
        owtr_pkg::PH_R1_SETTLE, owtr_pkg::PH_R2_SETTLE: begin
          slot_us = slot_us + 21'd1;
          if (slot_us >= SETTLE_US) enter_phase(owtr_pkg::phase_t'(seq_phase + 4'd1));
        end
        owtr_pkg::PH_SKIP1, owtr_pkg::PH_CONVERT, owtr_pkg::PH_SKIP2,
        owtr_pkg::PH_READPAD: begin
          drive = cmd_byte[0] ? (slot_us < SHORT_PULSE_US) : (slot_us < LONG_PULSE_US);
          slot_us = slot_us + 21'd1;
          if (slot_us >= WRITE_SLOT_US) begin
            slot_us = '0;
            cmd_byte = cmd_byte >> 1;
            bit_idx = bit_idx + 5'd1;
            if (bit_idx >= 5'd8) enter_phase(owtr_pkg::phase_t'(seq_phase + 4'd1));
          end
        end
        owtr_pkg::PH_CONV_WAIT: begin
          slot_us = slot_us + 21'd1;
          if (slot_us >= {1'b0, conv_wait_us}) enter_phase(owtr_pkg::PH_R2_LOW);
        end
        owtr_pkg::PH_READ: begin
          drive = slot_us < SHORT_PULSE_US;
          if (slot_us == READ_SAMPLE_US && beat.bus_level) shift_word[bit_idx[3:0]] = 1'b1;
          slot_us = slot_us + 21'd1;
          if (slot_us >= READ_SLOT_US) begin
            slot_us = '0;
            bit_idx = bit_idx + 5'd1;
            if (bit_idx >= 5'd16) begin
              last_word = shift_word;
              seq_phase = owtr_pkg::PH_IDLE;
              bit_idx = '0;
              done = 1'b1;
            end
          end
        end
        default: seq_phase = owtr_pkg::PH_IDLE;
      endcase
    end
    r.drive_low      = drive;
    r.busy_res       = seq_phase != owtr_pkg::PH_IDLE;
    r.done_res       = done;
    r.presence_seen  = present;
    r.raw_word       = last_word;
    r.is_negative    = last_word[15];
    r.magnitude      = last_word[15] ? (~last_word + 16'd1) : last_word;
    return r;
  endfunction

  task check_field(input string field, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    owtr_pkg::out_beat_t want;
    if (!rst_n) begin
      conv_wait_us = 20'd750000;
      seq_phase = owtr_pkg::PH_IDLE;
      slot_us = '0;
      bit_idx = '0;
      cmd_byte = '0;
      shift_word = '0;
      present = 1'b0;
      last_word = '0;
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_wr_en) conv_wait_us = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat expected none actual %h", $time, out_data);
        end else begin
          want = expected_q.pop_front();
          check_field("drive_low", want.drive_low, out_data.drive_low);
          check_field("busy_res", want.busy_res, out_data.busy_res);
          check_field("done_res", want.done_res, out_data.done_res);
          check_field("presence_seen", want.presence_seen, out_data.presence_seen);
          check_field("raw_word", want.raw_word, out_data.raw_word);
          check_field("is_negative", want.is_negative, out_data.is_negative);
          check_field("magnitude", want.magnitude, out_data.magnitude);
        end
      end
      if (in_valid && in_ready) expected_q.push_back(predict_result(in_data));
    end
    pending = expected_q.size();
  end

endmodule

// File: test/one_wire_temperature_reader_tb.sv
`timescale 1ns / 1ps
// Top of the one-wire temperature reader testbench: clock, reset, stimulus and verdict.
module one_wire_temperature_reader_tb;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  owtr_pkg::in_beat_t          in_data;
  logic                        out_valid;
  logic                        out_ready;
  owtr_pkg::out_beat_t         out_data;
  logic                        cfg_wr_en;
  logic [owtr_pkg::WAIT_W-1:0] cfg_wr_data;
  int                          mismatches;
  int                          pending;
  int unsigned                 send_idle_pct;
  int unsigned                 recv_idle_pct;
  int unsigned                 wait_cfg;

  one_wire_temperature_reader dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  owtr_result_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("one_wire_temperature_reader_tb: FAIL");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(input logic beat_kind, input logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{kind: beat_kind, bus_level: level};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_wait(input int unsigned value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value[owtr_pkg::WAIT_W-1:0];
    wait_cfg = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic idle_ticks(input int unsigned count);
    repeat (count) send_item(owtr_pkg::KIND_TICK, 1'($urandom_range(1)));
  endtask

  // Runs one complete read, placing the presence and data levels on the sampled ticks.
  // The idling of sender and receiver changes after each third of the read.
  task automatic run_read(input logic [15:0] word, input logic pres1, input logic pres2);
    int unsigned total;
    int unsigned r1_at;
    int unsigned r2_at;
    int unsigned rd_at;
    int unsigned pause_at;
    int unsigned k;
    logic        level;
    total = 4832 + wait_cfg;
    r1_at = 539;
    r2_at = 1936 + wait_cfg + 539;
    rd_at = 3872 + wait_cfg;
    pause_at = $urandom_range(total - 1);
    send_item(owtr_pkg::KIND_START, 1'($urandom_range(1)));
    k = 0;
    while (k < total) begin
      if ($urandom_range(99) < 2) begin
        send_item(owtr_pkg::KIND_START, 1'($urandom_range(1)));
      end else begin
        level = 1'($urandom_range(1));
        if (k == r1_at) level = !pres1;
        else if (k == r2_at) level = !pres2;
        else if (k >= rd_at && (k - rd_at) % 60 == 14) level = word[(k - rd_at) / 60];
        send_item(owtr_pkg::KIND_TICK, level);
        if (k == pause_at) drain();
        if (k == total / 3) begin
          send_idle_pct = 47;
          recv_idle_pct = 35;
        end else if (k == (2 * total) / 3) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        k++;
      end
    end
    idle_ticks($urandom_range(20, 1));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    send_idle_pct = 35;
    recv_idle_pct = 47;
    wait_cfg = 750000;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    set_wait(0);
    send_item(owtr_pkg::KIND_TICK, 1'b0);
    send_item(owtr_pkg::KIND_TICK, 1'b1);
    set_wait(2);
    run_read(16'hFE6F, 1'b1, 1'b0);

    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("one_wire_temperature_reader_tb: PASS");
    end else begin
      $display("one_wire_temperature_reader_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: one_wire_temperature_reader.f
+incdir+hdl
hdl/owtr_pkg.sv
hdl/owtr_seq.sv
hdl/one_wire_temperature_reader.sv
test/owtr_result_checker.sv
test/one_wire_temperature_reader_tb.sv
